### rtl/gfc_pkg.sv
package gfc_pkg;

  localparam int MAX_CANVAS_WIDTH  = 512;
  localparam int MAX_CANVAS_HEIGHT = 512;
  localparam int XW = $clog2(MAX_CANVAS_WIDTH + 1);
  localparam int YW = $clog2(MAX_CANVAS_HEIGHT + 1);
  localparam int STORE_DEPTH = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
  localparam int AW = $clog2(STORE_DEPTH);

  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_PIXEL  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_NO_FRAME = 2'd2;
  localparam logic [1:0] ST_OUTSIDE  = 2'd3;

  localparam logic [2:0] DISP_BACKGROUND = 3'd2;
  localparam logic [2:0] DISP_PREVIOUS   = 3'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BG     = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] meta_width;
    logic [15:0] meta_height;
    logic [15:0] decoded_width;
    logic [15:0] decoded_height;
    logic [2:0]  disposal;
    logic        first_frame;
    logic [31:0] pixel_bgra;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_bgra;
    logic        pixel_written;
    logic        frame_done;
  } result_t;

  // one blended colour channel: (s*a + d*(255-a) + 127) / 255
  function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] a);
    logic [16:0] t;
    logic [25:0] q;
    t = 17'(s) * 17'(a) + 17'(d) * 17'(8'd255 - a) + 17'd127;
    // divide by 255 via reciprocal: (t*257 + 257) >> 16 is exact for t < 65536
    q = 26'(t) * 26'd257 + 26'd257;
    return q[23:16];
  endfunction

endpackage

### rtl/gfc_if.sv
interface gfc_item_if;
  import gfc_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gfc_result_if;
  import gfc_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/gfc_queue.sv
module gfc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gfc_pkg::item_t  push_data,
  output logic            full,
  input  logic            pop,
  output gfc_pkg::item_t  pop_data,
  output logic            empty
);
  import gfc_pkg::*;

  item_t      slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full     = (count == 3'd4);
  assign empty    = (count == 3'd0);
  assign pop_data = slots[rd_ptr];

  // four-deep request queue between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end
endmodule

### rtl/gfc_back.sv
module gfc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  gfc_pkg::item_t  req,
  output logic            req_pop,
  input  logic [9:0]      canvas_width,
  input  logic [9:0]      canvas_height,
  input  logic [31:0]     background_bgra,
  output logic            res_valid,
  input  logic            res_ready,
  output gfc_pkg::result_t res,
  output logic            busy
);
  import gfc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;  // fill rectangle with background
  localparam logic [3:0] S_REST  = 4'd2;  // snapshot back to canvas
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_SNAP  = 4'd4;  // canvas to snapshot
  localparam logic [3:0] S_PIX   = 4'd5;  // wait for canvas read
  localparam logic [3:0] S_BLEND = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_DRAIN = 4'd9;  // last copy write

  logic [3:0] state;

  logic [31:0] canvas_mem [STORE_DEPTH];
  logic [31:0] snap_mem [STORE_DEPTH];
  logic [31:0] canvas_q;
  logic [31:0] snap_q;

  logic        snapshot_valid, frame_open;
  logic [15:0] prev_left, prev_top, prev_width, prev_height;
  logic [2:0]  prev_disposal;
  logic [15:0] cur_left, cur_top, copy_width, copy_height;
  logic [15:0] raster_width, raster_height, col_count, row_count;

  item_t       cur;
  result_t     out_r;
  logic        out_v;
  logic        snap_drain;  // drain target: 1 snapshot, 0 canvas

  // sweep counters and bounds
  logic [XW-1:0] sx, sx0, sx_end;
  logic [YW-1:0] sy, sy_end;
  logic [AW-1:0] addr_a, addr_w;
  logic          pend_w;
  logic [XW-1:0] ew;
  logic [YW-1:0] eh;
  logic [AW-1:0] pix_addr;

  // effective canvas size
  always_comb begin
    ew = (canvas_width == 10'd0) ? XW'(1) :
         (32'(canvas_width) > MAX_CANVAS_WIDTH) ? XW'(MAX_CANVAS_WIDTH) : XW'(canvas_width);
    eh = (canvas_height == 10'd0) ? YW'(1) :
         (32'(canvas_height) > MAX_CANVAS_HEIGHT) ? YW'(MAX_CANVAS_HEIGHT) : YW'(canvas_height);
  end

  function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
    return (a < b) ? a : b;
  endfunction

  logic [16:0] p_right, p_bottom;
  logic [15:0] fx0, fy0, fx1, fy1;
  logic        rej;
  logic [16:0] gx, gy;
  logic        pix_in;
  logic        last_col, last_row;

  always_comb begin
    p_right  = 17'(prev_left) + 17'(prev_width);
    p_bottom = 17'(prev_top) + 17'(prev_height);
    fx1 = (p_right > 17'(ew)) ? 16'(ew) : p_right[15:0];
    fy1 = (p_bottom > 17'(eh)) ? 16'(eh) : p_bottom[15:0];
    fx0 = min16(prev_left, 16'(ew));
    fy0 = min16(prev_top, 16'(eh));
    rej = (cur.decoded_width == 16'd0) || (cur.decoded_height == 16'd0) ||
          (cur.pos_x >= 16'(ew)) || (cur.pos_y >= 16'(eh));
    gx  = 17'(cur_left) + 17'(col_count);
    gy  = 17'(cur_top) + 17'(row_count);
    pix_in = (col_count < copy_width) && (row_count < copy_height) &&
             (gx < 17'(ew)) && (gy < 17'(eh)) && (cur.pixel_bgra[31:24] != 8'd0);
    pix_addr = AW'(gy[YW-1:0]) * AW'(ew) + AW'(gx[XW-1:0]);
    last_col = (col_count + 16'd1) >= raster_width;
    last_row = (row_count + 16'd1) >= raster_height;
  end

  assign addr_a  = AW'(sy) * AW'(ew) + AW'(sx);
  assign req_pop = (state == S_IDLE) && req_valid && !(out_v && !res_ready);
  assign res_valid = out_v;
  assign res = out_r;
  assign busy = (state != S_IDLE) || out_v;

  // memory ports
  logic        cw_en, sw_en;
  logic [AW-1:0] cw_addr, cr_addr, sw_addr;
  logic [31:0] cw_data;

  always_comb begin
    cw_en = 1'b0; cw_addr = addr_a; cw_data = background_bgra;
    sw_en = 1'b0; sw_addr = addr_w;
    cr_addr = addr_a;
    case (state)
      S_FILL: cw_en = (sy < sy_end) && (sx < sx_end);
      S_REST, S_DRAIN: begin
        cw_en = pend_w && !snap_drain; cw_addr = addr_w; cw_data = snap_q;
        sw_en = pend_w && snap_drain;
      end
      S_SNAP: sw_en = pend_w;
      S_PIX: cr_addr = pix_addr;
      S_READ: cr_addr = AW'(cur.pos_y[YW-1:0]) * AW'(ew) + AW'(cur.pos_x[XW-1:0]);
      S_BLEND: begin
        cw_en = pix_in; cw_addr = pix_addr;
        cw_data = {8'hFF,
                   blend_ch(cur.pixel_bgra[23:16], canvas_q[23:16], cur.pixel_bgra[31:24]),
                   blend_ch(cur.pixel_bgra[15:8], canvas_q[15:8], cur.pixel_bgra[31:24]),
                   blend_ch(cur.pixel_bgra[7:0], canvas_q[7:0], cur.pixel_bgra[31:24])};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cw_en) canvas_mem[cw_addr] <= cw_data;
    canvas_q <= canvas_mem[cr_addr];
    if (sw_en) snap_mem[sw_addr] <= canvas_q;
    snap_q <= snap_mem[addr_a];
  end

  logic last_cell;
  assign last_cell = (sx == ew - XW'(1)) && (sy == eh - YW'(1));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_v <= 1'b0;
      snapshot_valid <= 1'b0; frame_open <= 1'b0;
      prev_left <= '0; prev_top <= '0; prev_width <= '0; prev_height <= '0;
      prev_disposal <= '0;
      cur_left <= '0; cur_top <= '0; copy_width <= '0; copy_height <= '0;
      raster_width <= '0; raster_height <= '0; col_count <= '0; row_count <= '0;
      pend_w <= 1'b0; snap_drain <= 1'b0;
      sx <= '0; sy <= '0; sx0 <= '0; sx_end <= '0; sy_end <= '0; addr_w <= '0;
    end else begin
      if (out_v && res_ready) out_v <= 1'b0;
      case (state)
        S_IDLE: if (req_pop) begin
          cur <= req;
          out_r <= {(req.operation == OP_PIXEL && !frame_open) ? ST_NO_FRAME : ST_OK,
                    32'd0, 1'b0, 1'b0};
          case (req.operation)
            OP_HEADER: begin
              frame_open <= 1'b0;
              pend_w <= 1'b0;
              if (req.first_frame) begin
                snapshot_valid <= 1'b0;
                prev_left <= '0; prev_top <= '0; prev_width <= '0; prev_height <= '0;
                prev_disposal <= '0;
                sx <= '0; sy <= '0;
                sx0 <= '0; sx_end <= ew; sy_end <= eh;
                state <= S_FILL;
              end else if (prev_disposal == DISP_BACKGROUND) begin
                sx <= XW'(fx0); sy <= YW'(fy0); sx0 <= XW'(fx0);
                sx_end <= XW'(fx1); sy_end <= YW'(fy1);
                state <= S_FILL;
              end else if (prev_disposal == DISP_PREVIOUS && snapshot_valid) begin
                sx <= '0; sy <= '0;
                snap_drain <= 1'b0;
                state <= S_REST;
              end else begin
                state <= S_CHECK;
              end
            end
            OP_PIXEL: state <= frame_open ? S_PIX : S_OUT;
            OP_READ: state <= S_READ;
            default: state <= S_OUT;
          endcase
        end
        S_FILL: begin
          if (sy >= sy_end || sx0 >= sx_end) state <= S_CHECK;
          else if (sx == sx_end - XW'(1)) begin
            sx <= sx0;
            sy <= sy + YW'(1);
            if (sy == sy_end - YW'(1)) state <= S_CHECK;
          end else sx <= sx + XW'(1);
        end
        S_REST, S_SNAP: begin
          pend_w <= 1'b1; addr_w <= addr_a;
          if (last_cell) state <= S_DRAIN;
          else if (sx == ew - XW'(1)) begin sx <= '0; sy <= sy + YW'(1); end
          else sx <= sx + XW'(1);
        end
        S_DRAIN: begin
          pend_w <= 1'b0;
          state <= snap_drain ? S_OUT : S_CHECK;
        end
        S_CHECK: begin
          snapshot_valid <= !rej && (cur.disposal == DISP_PREVIOUS);
          if (rej) begin
            out_r.status <= ST_REJECT; state <= S_OUT;
          end else begin
            cur_left <= cur.pos_x; cur_top <= cur.pos_y;
            copy_width <= min16(min16(cur.decoded_width, cur.meta_width),
                                16'(ew) - cur.pos_x);
            copy_height <= min16(min16(cur.decoded_height, cur.meta_height),
                                 16'(eh) - cur.pos_y);
            raster_width <= cur.decoded_width; raster_height <= cur.decoded_height;
            col_count <= '0; row_count <= '0;
            frame_open <= 1'b1;
            prev_left <= cur.pos_x; prev_top <= cur.pos_y;
            prev_width <= cur.meta_width; prev_height <= cur.meta_height;
            prev_disposal <= cur.disposal;
            if (cur.disposal == DISP_PREVIOUS) begin
              snap_drain <= 1'b1;
              sx <= '0; sy <= '0; pend_w <= 1'b0;
              state <= S_SNAP;
            end else state <= S_OUT;
          end
        end
        S_PIX: state <= S_BLEND;
        S_BLEND: begin
          out_r <= {ST_OK, 32'd0, pix_in, last_col && last_row};
          if (last_col) begin
            col_count <= '0;
            if (last_row) begin
              row_count <= '0; frame_open <= 1'b0;
            end else row_count <= row_count + 16'd1;
          end else col_count <= col_count + 16'd1;
          state <= S_OUT;
        end
        S_READ: state <= S_OUT;
        S_OUT: begin
          if (cur.operation == OP_READ) begin
            if (cur.pos_x >= 16'(ew) || cur.pos_y >= 16'(eh)) out_r.status <= ST_OUTSIDE;
            else out_r.read_bgra <= canvas_q;
          end
          out_v <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/gfc_front.sv
module gfc_front (
  input  logic           clk,
  input  logic           rst,
  gfc_item_if.sink       in_ch,
  gfc_cfg_if.sink        cfg,
  input  logic           q_full,
  output logic           q_push,
  output gfc_pkg::item_t q_data,
  output logic [9:0]     canvas_width,
  output logic [9:0]     canvas_height,
  output logic [31:0]    background_bgra
);
  import gfc_pkg::*;

  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full;
  assign q_data = in_ch.data;
  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width <= 10'd512; canvas_height <= 10'd512; background_bgra <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WIDTH:  canvas_width <= cfg.wdata[9:0];
        REG_HEIGHT: canvas_height <= cfg.wdata[9:0];
        REG_BG:     background_bgra <= cfg.wdata;
        default: ;
      endcase
    end
  end
endmodule

### rtl/gif_frame_compositor_top.sv
// channel   dir  payload
// in_ch     in   item_t request fields
// out_ch    out  result_t status, read_bgra, pixel_written, frame_done
// cfg       in   index 2b, wdata 32b
// a pixel passes the back sequencer through S_PIX, S_BLEND and S_OUT, a read
// through S_READ and S_OUT; a header holds the back end for one pass over the
// fill rectangle, or for a pass over the whole canvas for a restore or snapshot copy
// rst is synchronous; memories are not cleared
// a four-deep queue keeps taking requests, until it is full, while the back end walks the canvas
module gif_frame_compositor_top (
  input logic        clk,
  input logic        rst,
  gfc_item_if.sink   in_ch,
  gfc_result_if.source out_ch,
  gfc_cfg_if.sink    cfg
);
  import gfc_pkg::*;

  logic        q_full, q_push, q_empty, q_pop, busy;
  item_t       q_in, q_out;
  logic [9:0]  cw, ch;
  logic [31:0] bg;

  gfc_front u_front (
    .clk, .rst, .in_ch, .cfg, .q_full, .q_push, .q_data(q_in),
    .canvas_width(cw), .canvas_height(ch), .background_bgra(bg)
  );

  gfc_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  gfc_back u_back (
    .clk, .rst, .req_valid(!q_empty), .req(q_out), .req_pop(q_pop),
    .canvas_width(cw), .canvas_height(ch), .background_bgra(bg),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data), .busy
  );

  // never pop an empty queue
  a_pop: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("pop from empty queue");
  // no push when full
  a_push: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("push into full queue");
  // a result only leaves while the back end is considered busy
  a_busy: assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> busy)
    else $error("result without busy back end");
endmodule
